@@ sv/abf_pkg.sv @@
// Shared types and constants for the attribute bitmap filter.
// Used by abf_front, abf_queue, abf_back and attribute_bitmap_filter; no dependencies.
package abf_pkg;

  // Bitmap geometry
  localparam int MAP_BITS  = 8192;
  localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
  localparam int BYTE_AW   = $clog2(MAP_BYTES);
  localparam int IDX_W     = 13;
  localparam int POS_W     = IDX_W + 1;
  localparam int BUCKET_W  = 11;

  // Configuration registers
  localparam int NUM_REGS = 7;
  localparam int CFG_AW   = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] REG_RESET [NUM_REGS] = '{
    13'd0, 13'd2048, 13'd3072, 13'd4096, 13'd5120, 13'd6144, 13'd7168
  };

  // Operation codes
  localparam logic [1:0] OP_ATTR  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TEST  = 2'd3;

  // Attribute kinds (also the index of the matching base register)
  localparam logic [2:0] KIND_SIZE   = 3'd0;
  localparam logic [2:0] KIND_UID    = 3'd1;
  localparam logic [2:0] KIND_GID    = 3'd2;
  localparam logic [2:0] KIND_ATIME  = 3'd3;
  localparam logic [2:0] KIND_CTIME  = 3'd4;
  localparam logic [2:0] KIND_MTIME  = 3'd5;
  localparam logic [2:0] KIND_TYPE   = 3'd6;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam logic [31:0] TYPE_MAX = 32'd64;

  // Timestamp bucketing: day start mod TIME_BUCKETS
  localparam logic [31:0] SECS_PER_DAY = 32'd86400;
  localparam logic [31:0] TIME_BUCKETS = 32'd1021;
  // Day start mod 1021 equals day number times this step, mod 1021
  localparam logic [31:0] DAY_STEP     = SECS_PER_DAY % TIME_BUCKETS;
  // floor(2^48 / 86400): quotient estimate is exact or one low
  localparam logic [31:0] DAY_RECIP    = 32'd3257812230;
  localparam int          DAY_SHIFT    = 48;
  localparam int          DAY_Q_W      = 16;
  // floor(2^35 / 1021): quotient estimate is exact or one low
  localparam logic [31:0] MOD_RECIP    = 32'd33653024;
  localparam int          MOD_SHIFT    = 35;
  localparam int          XMOD_W       = 25;
  localparam int          MOD_Q_W      = 16;

  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       attr_kind;
    logic [31:0]      attr_value;
    logic [IDX_W-1:0] bit_index;
  } in_word_t;

  typedef struct packed {
    logic             was_set;
    logic [IDX_W-1:0] target_index;
    logic             out_of_range;
  } out_word_t;

  // What the back end does with a resolved position
  typedef enum logic [1:0] {
    ACT_SET,
    ACT_CLEAR,
    ACT_TEST,
    ACT_REJECT
  } act_e;

  typedef struct packed {
    act_e             act;
    logic [IDX_W-1:0] target_index;
  } job_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    F_IDLE,
    F_T1,
    F_T2,
    F_T3,
    F_T4,
    F_T5,
    F_RESOLVE
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_WAIT
  } back_state_e;

endpackage

@@ sv/abf_front.sv @@
// Front end: takes input words, computes the bucket and bitmap position, holds base registers.
// Depends on abf_pkg.
module abf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  abf_pkg::in_word_t in_word,
  input  logic              cfg_we,
  input  logic [abf_pkg::CFG_AW-1:0] cfg_index,
  input  logic [abf_pkg::IDX_W-1:0]  cfg_data,
  input  logic              clearing,
  output logic              push_valid,
  input  logic              push_stall,
  output abf_pkg::job_t     push_word
);

  abf_pkg::front_state_e state, state_next;
  abf_pkg::in_word_t     item;
  logic [abf_pkg::IDX_W-1:0] base_reg [abf_pkg::NUM_REGS];

  logic [63:0]                        prod_day;
  logic [abf_pkg::DAY_Q_W-1:0]        day_num;
  logic [abf_pkg::XMOD_W-1:0]         x_mod;
  logic [abf_pkg::XMOD_W+25:0]        prod_mod;
  logic [abf_pkg::BUCKET_W-1:0]       time_bucket;

  logic                               accept;
  logic                               is_time;
  logic [abf_pkg::DAY_Q_W-1:0]        day_est;
  logic [31:0]                        day_rem;
  logic [abf_pkg::MOD_Q_W-1:0]        mod_est;
  logic [abf_pkg::XMOD_W-1:0]         mod_rem;

  logic [abf_pkg::BUCKET_W-1:0]       bucket;
  logic [abf_pkg::IDX_W-1:0]          base;
  logic [abf_pkg::POS_W-1:0]          pos;
  logic                               bad_type;

  assign accept  = in_valid && !in_stall;
  assign is_time = (in_word.op == abf_pkg::OP_ATTR) &&
                   ((in_word.attr_kind == abf_pkg::KIND_ATIME) ||
                    (in_word.attr_kind == abf_pkg::KIND_CTIME) ||
                    (in_word.attr_kind == abf_pkg::KIND_MTIME));

  assign day_est = prod_day[abf_pkg::DAY_SHIFT +: abf_pkg::DAY_Q_W];
  assign day_rem = item.attr_value - 32'(32'(day_est) * abf_pkg::SECS_PER_DAY);
  assign mod_est = prod_mod[abf_pkg::MOD_SHIFT +: abf_pkg::MOD_Q_W];
  assign mod_rem = x_mod -
                   abf_pkg::XMOD_W'(32'(mod_est) * abf_pkg::TIME_BUCKETS);

  // Base registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < abf_pkg::NUM_REGS; i++) begin
        base_reg[i] <= abf_pkg::REG_RESET[i];
      end
    end else if (cfg_we && (32'(cfg_index) < abf_pkg::NUM_REGS)) begin
      base_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abf_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: hold the item, then step the timestamp reduction
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_word;
    end
    unique case (state)
      abf_pkg::F_T1: prod_day <= {32'd0, item.attr_value} * {32'd0, abf_pkg::DAY_RECIP};
      abf_pkg::F_T2: day_num  <= day_est +
                                 abf_pkg::DAY_Q_W'(day_rem >= abf_pkg::SECS_PER_DAY);
      abf_pkg::F_T3: x_mod    <= abf_pkg::XMOD_W'(32'(day_num) * abf_pkg::DAY_STEP);
      abf_pkg::F_T4: prod_mod <= (abf_pkg::XMOD_W+26)'(
                                   {39'd0, x_mod} * {32'd0, abf_pkg::MOD_RECIP});
      abf_pkg::F_T5: begin
        if (32'(mod_rem) >= abf_pkg::TIME_BUCKETS) begin
          time_bucket <= abf_pkg::BUCKET_W'(32'(mod_rem) - abf_pkg::TIME_BUCKETS);
        end else begin
          time_bucket <= abf_pkg::BUCKET_W'(mod_rem);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abf_pkg::F_IDLE: begin
        if (accept) begin
          state_next = is_time ? abf_pkg::F_T1 : abf_pkg::F_RESOLVE;
        end
      end
      abf_pkg::F_T1:      state_next = abf_pkg::F_T2;
      abf_pkg::F_T2:      state_next = abf_pkg::F_T3;
      abf_pkg::F_T3:      state_next = abf_pkg::F_T4;
      abf_pkg::F_T4:      state_next = abf_pkg::F_T5;
      abf_pkg::F_T5:      state_next = abf_pkg::F_RESOLVE;
      abf_pkg::F_RESOLVE: if (!push_stall) state_next = abf_pkg::F_IDLE;
      default:            state_next = abf_pkg::F_IDLE;
    endcase
  end

  // Bucket and base for the held item
  always_comb begin
    bucket   = '0;
    base     = '0;
    bad_type = 1'b0;
    unique case (item.attr_kind)
      abf_pkg::KIND_SIZE: begin
        base = base_reg[abf_pkg::KIND_SIZE];
        priority if (item.attr_value[31:10] == '0) begin
          bucket = '0;
        end else if (item.attr_value[31:20] == '0) begin
          bucket = {1'b0, item.attr_value[19:10]};
        end else if (item.attr_value[31:30] == '0) begin
          bucket = {1'b1, item.attr_value[29:20]};
        end else begin
          bucket = '1;
        end
      end
      abf_pkg::KIND_UID, abf_pkg::KIND_GID: begin
        base   = base_reg[item.attr_kind];
        bucket = {1'b0, item.attr_value[9:0]};
      end
      abf_pkg::KIND_ATIME, abf_pkg::KIND_CTIME, abf_pkg::KIND_MTIME: begin
        base   = base_reg[item.attr_kind];
        bucket = time_bucket;
      end
      abf_pkg::KIND_TYPE: begin
        base     = base_reg[abf_pkg::KIND_TYPE];
        bucket   = abf_pkg::BUCKET_W'(item.attr_value[6:0]);
        bad_type = (item.attr_value > abf_pkg::TYPE_MAX);
      end
      abf_pkg::KIND_UNUSED: bad_type = 1'b1;
      default:              bad_type = 1'b1;
    endcase
  end

  always_comb begin
    if (item.op == abf_pkg::OP_ATTR) begin
      pos = {1'b0, base} + abf_pkg::POS_W'(bucket);
    end else begin
      pos = {1'b0, item.bit_index};
    end
  end

  // Outputs
  always_comb begin
    in_stall   = (state != abf_pkg::F_IDLE) || clearing;
    push_valid = (state == abf_pkg::F_RESOLVE);
    push_word.target_index = pos[abf_pkg::IDX_W-1:0];
    priority if ((item.op == abf_pkg::OP_ATTR) && bad_type) begin
      push_word.act          = abf_pkg::ACT_REJECT;
      push_word.target_index = '0;
    end else if (32'(pos) >= abf_pkg::MAP_BITS) begin
      push_word.act = abf_pkg::ACT_REJECT;
    end else if (item.op == abf_pkg::OP_CLEAR) begin
      push_word.act = abf_pkg::ACT_CLEAR;
    end else if (item.op == abf_pkg::OP_TEST) begin
      push_word.act = abf_pkg::ACT_TEST;
    end else begin
      push_word.act = abf_pkg::ACT_SET;
    end
  end

endmodule

@@ sv/abf_queue.sv @@
// Short job queue between front and back ends.
// Depends on abf_pkg.
module abf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  abf_pkg::job_t push_word,
  output logic          pop_valid,
  input  logic          pop_stall,
  output abf_pkg::job_t pop_word
);

  abf_pkg::job_t               slots [abf_pkg::QDEPTH];
  logic [abf_pkg::QPTR_W-1:0]  wr_ptr;
  logic [abf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [abf_pkg::QCNT_W-1:0]  count;
  logic                        do_push;
  logic                        do_pop;

  assign push_stall = (32'(count) == abf_pkg::QDEPTH);
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == abf_pkg::QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == abf_pkg::QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

@@ sv/abf_back.sv @@
// Back end: clears the bitmap after reset, then reads one bitmap byte per job and
// rewrites it for set and clear jobs. Depends on abf_pkg.
module abf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_stall,
  input  abf_pkg::job_t      job_word,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_stall,
  output abf_pkg::out_word_t out_word
);

  logic [7:0] bitmap [abf_pkg::MAP_BYTES];

  abf_pkg::back_state_e         state, state_next;
  abf_pkg::job_t                cur;
  logic [abf_pkg::BYTE_AW-1:0]  clr_addr;
  logic [7:0]                   rd_data;

  logic                         take;
  logic                         load_out;
  logic                         clr_last;
  logic [abf_pkg::BYTE_AW-1:0]  cur_byte;
  logic [7:0]                   cur_mask;
  logic                         rd_en;
  logic                         wr_en;
  logic [abf_pkg::BYTE_AW-1:0]  wr_addr;
  logic [7:0]                   wr_data;

  assign take     = job_valid && !job_stall;
  assign clr_last = (32'(clr_addr) == abf_pkg::MAP_BYTES - 1);
  assign cur_byte = abf_pkg::BYTE_AW'(cur.target_index >> 3);
  assign cur_mask = 8'h80 >> cur.target_index[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= abf_pkg::B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == abf_pkg::B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Bitmap storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= bitmap[abf_pkg::BYTE_AW'(job_word.target_index >> 3)];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= job_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.target_index <= cur.target_index;
      out_word.out_of_range <= (cur.act == abf_pkg::ACT_REJECT);
      out_word.was_set      <= (cur.act != abf_pkg::ACT_REJECT) && |(rd_data & cur_mask);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      abf_pkg::B_CLEAR: if (clr_last) state_next = abf_pkg::B_IDLE;
      abf_pkg::B_IDLE:  if (take) state_next = abf_pkg::B_WAIT;
      abf_pkg::B_WAIT:  if (load_out) state_next = abf_pkg::B_IDLE;
      default:          state_next = abf_pkg::B_CLEAR;
    endcase
  end

  always_comb begin
    clearing  = (state == abf_pkg::B_CLEAR);
    job_stall = (state != abf_pkg::B_IDLE);
    rd_en     = take;
    load_out  = (state == abf_pkg::B_WAIT) && (!out_valid || !out_stall);
    wr_en     = 1'b0;
    wr_addr   = cur_byte;
    wr_data   = rd_data;
    unique case (state)
      abf_pkg::B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      abf_pkg::B_WAIT: begin
        if (load_out && (cur.act == abf_pkg::ACT_SET)) begin
          wr_en   = 1'b1;
          wr_data = rd_data | cur_mask;
        end else if (load_out && (cur.act == abf_pkg::ACT_CLEAR)) begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~cur_mask;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ sv/attribute_bitmap_filter.sv @@
// Top level of the attribute bitmap filter: front end, job queue and bitmap back end.
// Depends on abf_pkg, abf_front, abf_queue and abf_back.
//
// Keeps an 8192-bit presence bitmap of file attributes. An input word either names an
// attribute (size, uid, gid, atime, ctime, mtime or type) and its value, which is bucketed
// and offset by that kind's base register, or addresses one bit directly to set, clear or
// test it. Every input word yields exactly one output word: the bit's previous value, the
// resolved position and an out-of-range flag; an out-of-range word leaves the map alone.
// After reset the bitmap is swept clear one byte per cycle, all 1024 bytes, during which
// in_stall stays high (base register writes are taken throughout). The front end takes
// no new word until it has resolved the previous one, which for timestamp words includes a
// day-and-modulo reduction through five registered steps of one constant multiplication
// each. The back end reads one bitmap byte per word, writes it back for sets and clears,
// and takes no new word until its result is loaded. A two-word queue lets the front end
// resolve the next word while the back end works or while a result waits to be taken.
module attribute_bitmap_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  abf_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output abf_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [abf_pkg::CFG_AW-1:0] cfg_index,
  input  logic [abf_pkg::IDX_W-1:0]  cfg_data
);

  // Front to queue
  logic          push_valid;
  logic          push_stall;
  abf_pkg::job_t push_word;

  // Queue to back
  logic          job_valid;
  logic          job_stall;
  abf_pkg::job_t job_word;

  // Hold off input words while the bitmap is being cleared
  logic          clearing;

  abf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_word  (push_word)
  );

  abf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_word  (push_word),
    .pop_valid  (job_valid),
    .pop_stall  (job_stall),
    .pop_word   (job_word)
  );

  abf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job_word  (job_word),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

@@ verif/tb_attribute_bitmap_filter.sv @@
// Self-checking testbench for attribute_bitmap_filter: directed and random words,
// a bitmap scoreboard that predicts every result, random idling on both channels.
// Depends on abf_pkg and the attribute_bitmap_filter RTL.
module tb_attribute_bitmap_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import abf_pkg::*;

  // Register index that matches no base register; a write to it must be dropped
  localparam logic [CFG_AW-1:0] CFG_NO_REG = CFG_AW'(NUM_REGS);
  // Cycles with no handshake at all before the run is declared hung; the post-reset
  // sweep alone holds in_stall high while all 1024 bitmap bytes are cleared
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 125;

  // Tracks the presence bitmap and base registers, and the results still owed
  class bitmap_scoreboard;
    bit               presence [MAP_BITS];
    logic [IDX_W-1:0] base [NUM_REGS];
    out_word_t        owed_q [$];
    logic [IDX_W-1:0] recent [32];
    int unsigned      recent_wr;
    int unsigned      errors;
    int unsigned      compared;

    function new();
      foreach (presence[i]) presence[i] = 1'b0;
      foreach (base[i]) base[i] = REG_RESET[i];
      foreach (recent[i]) recent[i] = '0;
      recent_wr = 0;
      errors = 0;
      compared = 0;
    endfunction

    function void write_base(logic [CFG_AW-1:0] idx, logic [IDX_W-1:0] data);
      if (idx < NUM_REGS) base[idx] = data;
    endfunction

    // Resolve one word against the bitmap and apply its effect
    function out_word_t resolve(in_word_t w);
      logic [31:0] val;
      logic [31:0] bucket;
      logic [31:0] day;
      logic [31:0] pos;
      out_word_t   r;
      val = w.attr_value;
      bucket = '0;
      r = '0;
      if (w.op == OP_ATTR) begin
        case (w.attr_kind)
          KIND_SIZE: begin
            if (val < 32'd1024) bucket = '0;
            else if (val < 32'd1048576) bucket = val / 32'd1024;
            else if (val < 32'h4000_0000) bucket = 32'd1024 + val / 32'd1048576;
            else bucket = 32'd2047;
          end
          KIND_UID, KIND_GID: bucket = val % 32'd1024;
          KIND_ATIME, KIND_CTIME, KIND_MTIME: begin
            day = val - val % SECS_PER_DAY;
            bucket = day % TIME_BUCKETS;
          end
          KIND_TYPE: bucket = val;
          default: bucket = '0;
        endcase
        if (w.attr_kind == KIND_UNUSED || (w.attr_kind == KIND_TYPE && val > TYPE_MAX)) begin
          r.out_of_range = 1'b1;
          return r;
        end
        pos = 32'(base[w.attr_kind]) + bucket;
      end else begin
        pos = 32'(w.bit_index);
      end
      r.target_index = pos[IDX_W-1:0];
      if (pos >= MAP_BITS) begin
        r.out_of_range = 1'b1;
        return r;
      end
      r.was_set = presence[pos];
      case (w.op)
        OP_ATTR, OP_SET: presence[pos] = 1'b1;
        OP_CLEAR:        presence[pos] = 1'b0;
        default:         ;
      endcase
      recent[recent_wr] = pos[IDX_W-1:0];
      recent_wr = (recent_wr + 1) % 32;
      return r;
    endfunction

    function void record_request(in_word_t w);
      owed_q.push_back(resolve(w));
    endfunction

    function void check_reply(out_word_t got);
      out_word_t exp;
      if (owed_q.size() == 0) begin
        $error("result word with none outstanding: %h", got);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      compared++;
      if (got.was_set !== exp.was_set) begin
        $error("was_set: expected %0d, got %0d", exp.was_set, got.was_set);
        errors++;
      end
      if (got.target_index !== exp.target_index) begin
        $error("target_index: expected %0d, got %0d", exp.target_index, got.target_index);
        errors++;
      end
      if (got.out_of_range !== exp.out_of_range) begin
        $error("out_of_range: expected %0d, got %0d", exp.out_of_range, got.out_of_range);
        errors++;
      end
    endfunction

    function logic [IDX_W-1:0] recent_position();
      return recent[$urandom_range(31, 0)];
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_index = '0;
  logic [IDX_W-1:0]    cfg_data = '0;

  bitmap_scoreboard sb;
  bit               idle_on = 1'b1;
  int unsigned      hang_count = 0;
  int unsigned      attr_words = 0;
  int unsigned      raw_words = 0;
  int unsigned      base_settings = 0;

  attribute_bitmap_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, about 8 percent of the time, unless idling is off
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99, 0) < 8);
  end

  // Compare every result word taken; values are those sampled at the edge
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) sb.check_reply(out_word);
  end

  // Watchdog: give up when no word and no register write has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || cfg_we) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  function automatic in_word_t make_word(logic [1:0] op, logic [2:0] kind, logic [31:0] val,
                                         logic [IDX_W-1:0] idx);
    in_word_t w;
    w.op = op;
    w.attr_kind = kind;
    w.attr_value = val;
    w.bit_index = idx;
    return w;
  endfunction

  // Random word: half attribute words, with values steered towards bucket edges, and
  // raw words that often revisit positions touched a moment ago
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    w.attr_value = $urandom;
    w.bit_index = IDX_W'($urandom);
    pick = $urandom_range(20, 0);
    w.attr_kind = (pick == 20) ? KIND_UNUSED : 3'(pick % 7);
    pick = $urandom_range(9, 0);
    if (pick < 5) w.op = OP_ATTR;
    else if (pick < 7) w.op = OP_SET;
    else if (pick < 8) w.op = OP_CLEAR;
    else w.op = OP_TEST;
    if (w.op == OP_ATTR) begin
      case (w.attr_kind)
        KIND_SIZE: begin
          case ($urandom_range(4, 0))
            0:       w.attr_value = $urandom_range(1023, 0);
            1:       w.attr_value = $urandom_range(32'd1048575, 32'd1024);
            2:       w.attr_value = $urandom_range(32'h3FFF_FFFF, 32'd1048576);
            3:       w.attr_value = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
            default: w.attr_value = $urandom;
          endcase
        end
        KIND_UID, KIND_GID: begin
          if ($urandom_range(1, 0)) w.attr_value = $urandom_range(31, 0);
        end
        KIND_ATIME, KIND_CTIME, KIND_MTIME: begin
          case ($urandom_range(2, 0))
            0: w.attr_value = 32'($urandom_range(49710, 0)) * SECS_PER_DAY
                              + ($urandom_range(1, 0) ? 32'd86399 : 32'd0);
            1: w.attr_value = $urandom_range(32'hFFFF_FFFF, 32'hFFFE_0000);
            default: ;
          endcase
        end
        KIND_TYPE: begin
          if ($urandom_range(3, 0) != 0) w.attr_value = $urandom_range(64, 0);
          else if ($urandom_range(1, 0)) w.attr_value = $urandom_range(80, 65);
        end
        default: ;
      endcase
    end else begin
      pick = $urandom_range(9, 0);
      if (pick < 5) w.bit_index = sb.recent_position();
      else if (pick == 5) w.bit_index = '0;
      else if (pick == 6) w.bit_index = '1;
    end
    return w;
  endfunction

  // Offer one word, with a random gap first; return just after the edge that takes it
  task automatic send_word(input in_word_t w);
    while (idle_on && $urandom_range(99, 0) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.record_request(w);
    if (w.op == OP_ATTR) attr_words++;
    else raw_words++;
  endtask

  // Drop valid and hold until every owed result has been taken, then settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it once the batch is done
  task automatic write_base(input logic [CFG_AW-1:0] idx, input logic [IDX_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_base(idx, data);
  endtask

  // Load every base register: all at the top of the map, or a random mix of extremes and other values
  task automatic load_bases(input bit all_top);
    logic [IDX_W-1:0] data;
    int unsigned      pick;
    for (int i = 0; i < NUM_REGS; i++) begin
      pick = $urandom_range(9, 0);
      if (all_top || pick < 2) data = '1;
      else if (pick < 4) data = '0;
      else data = IDX_W'($urandom);
      write_base(CFG_AW'(i), data);
    end
    // A write past the last register must leave everything alone
    write_base(CFG_NO_REG, IDX_W'($urandom));
    cfg_we <= 1'b0;
    base_settings++;
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset bases: raw ops on both ends of the map, then every bucket rule at its edges
    send_word(make_word(OP_TEST,  KIND_SIZE,   32'h0,        13'd0));
    send_word(make_word(OP_SET,   KIND_TYPE,   32'hFFFF_FFFF, 13'd0));
    send_word(make_word(OP_TEST,  KIND_SIZE,   32'h0,        13'd0));
    send_word(make_word(OP_CLEAR, KIND_UNUSED, 32'h0,        13'd0));
    send_word(make_word(OP_TEST,  KIND_SIZE,   32'h0,        13'd0));
    send_word(make_word(OP_SET,   KIND_UNUSED, 32'hFFFF_FFFF, 13'd8191));
    send_word(make_word(OP_TEST,  KIND_SIZE,   32'h0,        13'd8191));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'd0,        13'd8191));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'd1023,     13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'd1024,     13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'd1048575,  13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'd1048576,  13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'h3FFF_FFFF, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'h4000_0000, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'hFFFF_FFFF, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_UID,    32'hFFFF_FFFF, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_GID,    32'd1023,     13'd0));
    send_word(make_word(OP_ATTR,  KIND_ATIME,  32'd0,        13'd0));
    send_word(make_word(OP_ATTR,  KIND_CTIME,  32'd86399,    13'd0));
    send_word(make_word(OP_ATTR,  KIND_MTIME,  32'hFFFF_FFFF, 13'd0));
    // Largest legal type number, the first illegal one, and the unused kind
    send_word(make_word(OP_ATTR,  KIND_TYPE,   TYPE_MAX,     13'd0));
    send_word(make_word(OP_ATTR,  KIND_TYPE,   TYPE_MAX + 1, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_UNUSED, 32'd0,        13'd0));
    drain();

    // Bases at the top of the map: large buckets fall off the end, small ones land
    // on the last bit, which the raw set above already marked
    load_bases(1'b1);
    send_word(make_word(OP_ATTR,  KIND_SIZE,   32'hFFFF_FFFF, 13'd0));
    send_word(make_word(OP_ATTR,  KIND_UID,    32'd0,        13'd0));
    send_word(make_word(OP_ATTR,  KIND_TYPE,   32'd0,        13'd0));
    send_word(make_word(OP_ATTR,  KIND_TYPE,   32'hFFFF_FFFF, 13'd0));
    drain();

    // Random phases, each with fresh bases; one phase runs with no idling at all
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p != 2);
      load_bases(1'b0);
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(random_word());
      drain();
    end
    idle_on = 1'b1;

    if (sb.pending() != 0) begin
      $error("%0d result words never arrived", sb.pending());
      sb.errors++;
    end
    $display("Covered %0d attribute words and %0d raw words under %0d base settings.",
             attr_words, raw_words, base_settings + 1);
    $display("Compared %0d result words, %0d mismatches.", sb.compared, sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/abf_pkg.sv
sv/abf_front.sv
sv/abf_queue.sv
sv/abf_back.sv
sv/attribute_bitmap_filter.sv
verif/tb_attribute_bitmap_filter.sv
